@@ rtl/idtq_pkg.sv @@
package idtq_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_APPEND_NEXT   = 3'd0;
  localparam op_t OP_APPEND_LOWEST = 3'd1;
  localparam op_t OP_APPEND_GIVEN  = 3'd2;
  localparam op_t OP_GET           = 3'd3;
  localparam op_t OP_REMOVE_ID     = 3'd4;
  localparam op_t OP_REMOVE_HANDLE = 3'd5;
  localparam op_t OP_DEQUEUE       = 3'd6;
  localparam op_t OP_UNDEFINED     = 3'd7;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_BAD  = 2'd3;

  localparam int COUNT_W = 5;

endpackage

@@ rtl/idtq_if.sv @@
interface idtq_in_if #(
  parameter int ID_WIDTH     = 16,
  parameter int HANDLE_WIDTH = 32
) ();
  import idtq_pkg::*;
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic [ID_WIDTH-1:0]     entry_id;
  logic [HANDLE_WIDTH-1:0] handle;
  modport source (output valid, operation, entry_id, handle, input ready);
  modport sink (input valid, operation, entry_id, handle, output ready);
endinterface

interface idtq_out_if #(
  parameter int ID_WIDTH     = 16,
  parameter int HANDLE_WIDTH = 32
) ();
  import idtq_pkg::*;
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [ID_WIDTH-1:0]     result_id;
  logic [HANDLE_WIDTH-1:0] result_handle;
  logic [COUNT_W-1:0]      entry_count;
  logic                    cursor_valid;
  logic [ID_WIDTH-1:0]     cursor_id;
  modport source (output valid, status, result_id, result_handle, entry_count,
                  cursor_valid, cursor_id, input ready);
  modport sink (input valid, status, result_id, result_handle, entry_count,
                cursor_valid, cursor_id, output ready);
endinterface

@@ rtl/id_tagged_ordered_queue.sv @@
// Ordered queue of up to CAPACITY (id, handle) entries with an id allocator and a
// cursor. One request is taken at a time: a scan reads one entry per cycle from the
// entry memory, ending early when a hit is found; S_POST then decides; a removal
// then shifts the later entries down one per cycle; and S_CURS and S_OUT fetch the
// cursor's id into the registered result. The next request is taken only once the
// FSM is back in S_IDLE. in_req.ready is high only between requests; a finished
// result may wait on the output register while the next request is taken.
module id_tagged_ordered_queue #(
  parameter int CAPACITY     = 16,
  parameter int ID_WIDTH     = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  idtq_in_if.sink    in_req,
  idtq_out_if.source out_rsp
);
  import idtq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = $clog2(CAPACITY + 2);
  localparam int IW = ID_WIDTH;
  localparam int HW = HANDLE_WIDTH;
  localparam logic [IW-1:0] ID_ALL1 = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_POST, S_SHIFT, S_CURS, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [IW-1:0] id_mem [CAPACITY];
  logic [HW-1:0] hd_mem [CAPACITY];
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] rd_id_r;
  logic [HW-1:0] rd_h_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [IW-1:0] wd_id;
  logic [HW-1:0] wd_h;

  op_t           op_r, op_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] hit_id_r, hit_id_nxt;
  logic [HW-1:0] hit_h_r, hit_h_nxt;
  logic [CAPACITY:0] used_r, used_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] nsid_r, nsid_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic          curv_r, curv_nxt;
  status_t       st_r, st_nxt;
  logic [IW-1:0] rid_r, rid_nxt;
  logic [HW-1:0] rh_r, rh_nxt;
  logic [AW-1:0] sh_r, sh_nxt;
  logic          wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;

  logic          out_v_r, out_v_nxt;
  status_t       o_st_r, o_st_nxt;
  logic [IW-1:0] o_rid_r, o_rid_nxt;
  logic [HW-1:0] o_rh_r, o_rh_nxt;
  logic [COUNT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic          o_cv_r, o_cv_nxt;
  logic [IW-1:0] o_cid_r, o_cid_nxt;

  logic [BW-1:0] cand;
  logic [32:0]   cand_w;
  logic [31:0]   cnt_w;
  logic          full;
  logic          match;
  logic [AW-1:0] last;

  always_comb begin
    cand = BW'(CAPACITY);
    for (int k = CAPACITY; k >= 0; k--) begin
      if (!used_r[k]) begin
        cand = BW'(k);
      end
    end
  end

  assign cand_w = 33'(cand);
  assign cnt_w  = 32'(cnt_r);
  assign full   = (cnt_r == CW'(CAPACITY));
  assign last   = AW'(cnt_r - CW'(1));

  always_comb begin
    match = 1'b0;
    case (op_r)
      OP_APPEND_GIVEN, OP_GET, OP_REMOVE_ID: match = (rd_id_r == id_r);
      OP_REMOVE_HANDLE:                      match = (rd_h_r == h_r);
      OP_DEQUEUE:                            match = 1'b1;
      default:                               match = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    h_nxt       = h_r;
    idx_nxt     = idx_r;
    chk_v_nxt   = 1'b0;
    chk_idx_nxt = chk_idx_r;
    hit_nxt     = hit_r;
    pos_nxt     = pos_r;
    hit_id_nxt  = hit_id_r;
    hit_h_nxt   = hit_h_r;
    used_nxt    = used_r;
    cnt_nxt     = cnt_r;
    nsid_nxt    = nsid_r;
    cur_nxt     = cur_r;
    curv_nxt    = curv_r;
    st_nxt      = st_r;
    rid_nxt     = rid_r;
    rh_nxt      = rh_r;
    sh_nxt      = sh_r;
    wv_nxt      = 1'b0;
    wa_nxt      = wa_r;
    rd_addr     = idx_r[AW-1:0];
    we          = 1'b0;
    wa          = wa_r;
    wd_id       = rd_id_r;
    wd_h        = rd_h_r;
    out_v_nxt   = out_v_r && !out_rsp.ready;
    o_st_nxt    = o_st_r;
    o_rid_nxt   = o_rid_r;
    o_rh_nxt    = o_rh_r;
    o_cnt_nxt   = o_cnt_r;
    o_cv_nxt    = o_cv_r;
    o_cid_nxt   = o_cid_r;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.operation;
          id_nxt    = in_req.entry_id;
          h_nxt     = in_req.handle;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          used_nxt  = '0;
          st_nxt    = ST_MISS;
          rid_nxt   = ID_ALL1;
          rh_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_v_r) begin
          if (op_r == OP_APPEND_LOWEST) begin
            for (int k = 0; k <= CAPACITY; k++) begin
              if (33'(rd_id_r) == 33'(k)) begin
                used_nxt[k] = 1'b1;
              end
            end
          end
          if (match && !hit_r) begin
            hit_nxt    = 1'b1;
            pos_nxt    = chk_idx_r;
            hit_id_nxt = rd_id_r;
            hit_h_nxt  = rd_h_r;
          end
        end
        if (idx_r < cnt_r && !hit_r) begin
          idx_nxt     = idx_r + CW'(1);
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = idx_r[AW-1:0];
        end else if (!chk_v_r) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        state_nxt = S_CURS;
        wa        = cnt_r[AW-1:0];
        wd_h      = h_r;
        case (op_r)
          OP_APPEND_NEXT: begin
            if (full || nsid_r == ID_ALL1) begin
              st_nxt = ST_FULL;
            end else begin
              we       = 1'b1;
              wd_id    = nsid_r;
              nsid_nxt = nsid_r + IW'(1);
              st_nxt   = ST_OK;
              rid_nxt  = nsid_r;
            end
          end
          OP_APPEND_LOWEST: begin
            if (full || cand_w >= 33'(ID_ALL1)) begin
              st_nxt = ST_FULL;
            end else begin
              we      = 1'b1;
              wd_id   = cand_w[IW-1:0];
              st_nxt  = ST_OK;
              rid_nxt = cand_w[IW-1:0];
              if (cand_w[IW-1:0] >= nsid_r) begin
                nsid_nxt = cand_w[IW-1:0] + IW'(1);
              end
            end
          end
          OP_APPEND_GIVEN: begin
            if (id_r == ID_ALL1) begin
              st_nxt = ST_BAD;
            end else if (full) begin
              st_nxt = ST_FULL;
            end else if (hit_r) begin
              st_nxt = ST_BAD;
            end else begin
              we      = 1'b1;
              wd_id   = id_r;
              st_nxt  = ST_OK;
              rid_nxt = id_r;
              if (id_r >= nsid_r) begin
                nsid_nxt = id_r + IW'(1);
              end
            end
          end
          OP_GET: begin
            if (hit_r) begin
              st_nxt  = ST_OK;
              rid_nxt = hit_id_r;
              rh_nxt  = hit_h_r;
            end
          end
          OP_REMOVE_ID, OP_REMOVE_HANDLE, OP_DEQUEUE: begin
            if (hit_r && !(op_r == OP_REMOVE_HANDLE && h_r == '0)) begin
              st_nxt  = ST_OK;
              rid_nxt = hit_id_r;
              rh_nxt  = hit_h_r;
              if (curv_r) begin
                if (cur_r > pos_r) begin
                  cur_nxt = cur_r - AW'(1);
                end else if (cur_r == pos_r && pos_r == last) begin
                  cur_nxt = '0;
                end
              end
              cnt_nxt = cnt_r - CW'(1);
              if (cnt_r == CW'(1)) begin
                curv_nxt = 1'b0;
                cur_nxt  = '0;
              end
              sh_nxt    = pos_r;
              state_nxt = S_SHIFT;
            end
          end
          default: begin
            st_nxt = ST_MISS;
          end
        endcase
        if (we) begin
          cnt_nxt = cnt_r + CW'(1);
          if (!curv_r) begin
            curv_nxt = 1'b1;
            cur_nxt  = '0;
          end
        end
      end
      S_SHIFT: begin
        if (wv_r) begin
          we = 1'b1;
        end
        if (CW'(sh_r) < cnt_r) begin
          rd_addr = sh_r + AW'(1);
          wa_nxt  = sh_r;
          wv_nxt  = 1'b1;
          sh_nxt  = sh_r + AW'(1);
        end else if (!wv_r) begin
          state_nxt = S_CURS;
        end
      end
      S_CURS: begin
        rd_addr   = cur_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        rd_addr = cur_r;
        if (!out_v_r || out_rsp.ready) begin
          out_v_nxt = 1'b1;
          o_st_nxt  = st_r;
          o_rid_nxt = rid_r;
          o_rh_nxt  = rh_r;
          o_cnt_nxt = cnt_w[COUNT_W-1:0];
          o_cv_nxt  = curv_r;
          o_cid_nxt = curv_r ? rd_id_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      id_mem[wa] <= wd_id;
      hd_mem[wa] <= wd_h;
    end
    rd_id_r <= id_mem[rd_addr];
    rd_h_r  <= hd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      nsid_r  <= '0;
      cur_r   <= '0;
      curv_r  <= 1'b0;
      chk_v_r <= 1'b0;
      wv_r    <= 1'b0;
      hit_r   <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nsid_r  <= nsid_nxt;
      cur_r   <= cur_nxt;
      curv_r  <= curv_nxt;
      chk_v_r <= chk_v_nxt;
      wv_r    <= wv_nxt;
      hit_r   <= hit_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    h_r       <= h_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    hit_id_r  <= hit_id_nxt;
    hit_h_r   <= hit_h_nxt;
    used_r    <= used_nxt;
    st_r      <= st_nxt;
    rid_r     <= rid_nxt;
    rh_r      <= rh_nxt;
    sh_r      <= sh_nxt;
    wa_r      <= wa_nxt;
    o_st_r    <= o_st_nxt;
    o_rid_r   <= o_rid_nxt;
    o_rh_r    <= o_rh_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_cv_r    <= o_cv_nxt;
    o_cid_r   <= o_cid_nxt;
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_v_r;
  assign out_rsp.status        = o_st_r;
  assign out_rsp.result_id     = o_rid_r;
  assign out_rsp.result_handle = o_rh_r;
  assign out_rsp.entry_count   = o_cnt_r;
  assign out_rsp.cursor_valid  = o_cv_r;
  assign out_rsp.cursor_id     = o_cid_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cursor_present: assert property (@(posedge clk) disable iff (!rst_n)
    curv_r == (cnt_r != '0))
    else $error("cursor presence disagrees with occupancy");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    curv_r |-> (CW'(cur_r) < cnt_r))
    else $error("cursor beyond last entry");

  a_shift_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |=> !in_req.ready || $past(state_r == S_SHIFT) && !wv_r)
    else $error("request taken while entries still shifting");

endmodule
